// ----- rtl/core/tfd_pkg.sv -----
// shared types, constants and byte classification for the typed frame deframer
package tfd_pkg;

  localparam int MaxFrameLen = 1024;
  localparam int CountW      = $clog2(MaxFrameLen + 1);
  localparam int LenW        = 11;
  localparam int QueueDepth  = 4;
  localparam int QueuePtrW   = $clog2(QueueDepth);
  localparam int ChkStartIdx = 6;

  localparam logic [7:0] ByteSoh    = 8'h01;
  localparam logic [7:0] ByteEtx    = 8'h03;
  localparam logic [7:0] ByteEot    = 8'h04;
  localparam logic [7:0] ByteEnq    = 8'h05;
  localparam logic [7:0] ByteDle    = 8'h10;
  localparam logic [7:0] ByteNak    = 8'h15;
  localparam logic [7:0] ByteEtb    = 8'h17;
  localparam logic [7:0] ShortCheck = 8'hfe;

  typedef enum logic [2:0] {
    KIND_READY    = 3'd0,
    KIND_IDLE     = 3'd1,
    KIND_ERROR    = 3'd2,
    KIND_STATUS   = 3'd3,
    KIND_DATA     = 3'd4,
    KIND_CHECKSUM = 3'd5
  } frame_kind_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       chunk_end;
  } in_t;

  typedef struct packed {
    logic [7:0]      frame_byte;
    frame_kind_e     frame_kind;
    logic            frame_last;
    logic [LenW-1:0] frame_length;
    logic            check_ok;
    logic            length_overflow;
  } out_t;

  // one classified request as it sits in the queue
  typedef struct packed {
    logic [7:0]  rx_byte;
    logic        chunk_end;
    frame_kind_e kind;
    logic        is_eot;
    logic        is_term;
  } entry_t;

  function automatic frame_kind_e kind_of(input logic [7:0] b);
    frame_kind_e k;
    case (b)
      ByteEot: k = KIND_READY;
      ByteEnq: k = KIND_IDLE;
      ByteNak: k = KIND_ERROR;
      ByteDle: k = KIND_STATUS;
      ByteSoh: k = KIND_CHECKSUM;
      default: k = KIND_DATA;
    endcase
    return k;
  endfunction

endpackage

// ----- rtl/core/tfd_front.sv -----
// front end: accepts received bytes and classifies them for the queue
module tfd_front (
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tfd_pkg::in_t   in_data_i,
  output logic           push_o,
  input  logic           push_ready_i,
  output tfd_pkg::entry_t push_entry_o
);
  import tfd_pkg::*;

  assign in_ready_o = push_ready_i;
  assign push_o     = in_valid_i && push_ready_i;

  always_comb begin
    push_entry_o.rx_byte   = in_data_i.rx_byte;
    push_entry_o.chunk_end = in_data_i.chunk_end;
    push_entry_o.kind      = kind_of(in_data_i.rx_byte);
    push_entry_o.is_eot    = (in_data_i.rx_byte == ByteEot);
    push_entry_o.is_term   = (in_data_i.rx_byte inside {ByteEtx, ByteEtb});
  end

endmodule

// ----- rtl/core/tfd_queue.sv -----
// short queue of classified requests between front and back
module tfd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            push_ready_o,
  input  tfd_pkg::entry_t push_entry_i,
  output logic            pop_valid_o,
  input  logic            pop_i,
  output tfd_pkg::entry_t pop_entry_o
);
  import tfd_pkg::*;

  entry_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QueuePtrW:0]     count_q, count_d;
  logic                   do_push, do_pop;

  assign push_ready_o = (count_q != (QueuePtrW + 1)'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_entry_o  = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// ----- rtl/core/tfd_back.sv -----
// back end: frame state, length count, xor check and output register
module tfd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pop_valid_i,
  output logic            pop_o,
  input  tfd_pkg::entry_t pop_entry_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output tfd_pkg::out_t   out_data_o
);
  import tfd_pkg::*;

  frame_kind_e       kind_q, kind_d;
  logic              in_frame_q, in_frame_d;
  logic [CountW-1:0] count_q, count_d;
  logic [7:0]        xor_q, xor_d;
  logic              await_q, await_d;
  logic              drop_q, drop_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_q, out_d;

  frame_kind_e       kind;
  logic [CountW-1:0] idx;
  logic [7:0]        acc;
  logic              aw, last, ok, ovf, emit;
  logic [7:0]        chk;

  assign pop_o       = pop_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    kind_d      = kind_q;
    in_frame_d  = in_frame_q;
    count_d     = count_q;
    xor_d       = xor_q;
    await_d     = await_q;
    drop_d      = drop_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    // a new frame starts from cleared state
    kind = in_frame_q ? kind_q : pop_entry_i.kind;
    idx  = in_frame_q ? count_q : '0;
    acc  = in_frame_q ? xor_q : 8'h00;
    aw   = in_frame_q ? await_q : 1'b0;
    ovf  = (idx >= CountW'(MaxFrameLen));
    last = 1'b0;
    ok   = 1'b0;
    chk  = (idx < CountW'(ChkStartIdx)) ? ShortCheck : acc;
    emit = 1'b0;

    if (pop_o) begin
      if (drop_q) begin
        if (pop_entry_i.chunk_end) begin
          drop_d = 1'b0;
        end
      end else begin
        emit = 1'b1;
        if (idx == '0) begin
          last = kind inside {KIND_READY, KIND_IDLE, KIND_ERROR};
        end else begin
          case (kind)
            KIND_STATUS: last = 1'b1;
            KIND_DATA:   last = pop_entry_i.is_eot;
            KIND_CHECKSUM: begin
              if (aw) begin
                ok   = (chk == pop_entry_i.rx_byte);
                last = 1'b1;
              end else begin
                if (idx >= CountW'(ChkStartIdx)) begin
                  acc = acc ^ pop_entry_i.rx_byte;
                end
                if (pop_entry_i.is_term) begin
                  aw = 1'b1;
                end
              end
            end
            default: last = 1'b0;
          endcase
        end
        kind_d  = kind;
        count_d = ovf ? idx : idx + 1'b1;
        xor_d   = acc;
        if (last) begin
          in_frame_d = 1'b0;
          await_d    = 1'b0;
          drop_d     = !pop_entry_i.chunk_end;
        end else begin
          in_frame_d = 1'b1;
          await_d    = aw;
        end
        out_valid_d           = 1'b1;
        out_d.frame_byte      = pop_entry_i.rx_byte;
        out_d.frame_kind      = kind;
        out_d.frame_last      = last;
        out_d.frame_length    = LenW'(count_d);
        out_d.check_ok        = ok;
        out_d.length_overflow = ovf;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q      <= KIND_READY;
      in_frame_q  <= 1'b0;
      count_q     <= '0;
      xor_q       <= 8'h00;
      await_q     <= 1'b0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      kind_q      <= kind_d;
      in_frame_q  <= in_frame_d;
      count_q     <= count_d;
      xor_q       <= xor_d;
      await_q     <= await_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

`ifndef SYNTHESIS
  a_drop_outside_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(drop_q && in_frame_q))
    else $error("dropping while a frame is open");

  a_check_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.check_ok) |-> (out_q.frame_last && out_q.frame_kind == KIND_CHECKSUM))
    else $error("check_ok outside final byte of a checksummed frame");

  a_await_only_checksum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    await_q |-> (in_frame_q && kind_q == KIND_CHECKSUM))
    else $error("awaiting checksum outside a checksummed frame");

  a_pop_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && !drop_q) |=> out_valid_q)
    else $error("popped frame byte did not reach the output");
`endif

endmodule

// ----- rtl/core/typed_frame_deframer_xor_check_unit.sv -----
// top level of the typed frame deframer with xor check
//
// input channel: one received byte per request with its chunk-end mark,
// valid/ready handshake on in_valid_i / in_ready_o
// output channel: one request per frame byte with kind, last mark, running
// length, xor check result and overflow flag, on out_valid_o / out_ready_i
// bytes dropped after a finished frame within the same chunk give no output
// a byte accepted on the input is written into the queue, then popped into the
// output register and presented on out_data_o from there
// throughput: one byte per cycle while the receiver accepts, set by the frame
// state update in the back end
// a four-entry queue separates the classifying front end from the back end;
// when the receiver stalls the output register holds, the queue fills and
// in_ready_o falls only once all four entries are taken
// reset clears frame state, queue pointers and the output valid; no item is
// in flight after reset
module typed_frame_deframer_xor_check_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tfd_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tfd_pkg::out_t  out_data_o
);
  import tfd_pkg::*;

  logic   push, push_ready, pop_valid, pop;
  entry_t push_entry, pop_entry;

  tfd_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  tfd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_entry_o  (pop_entry)
  );

  tfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_o       (pop),
    .pop_entry_i (pop_entry),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- dv/typed_frame_deframer_xor_check_unit_tb.sv -----
// self-checking testbench for the typed frame deframer with xor check
module typed_frame_deframer_xor_check_unit_tb;
  import tfd_pkg::*;

  localparam int NumDirected = 25;
  localparam int RandomItems = 1650;
  localparam int LongFrameAt = NumDirected + 300;
  localparam int PauseAt     = NumDirected + 500;
  localparam int LongHoldAt  = 200;
  localparam int LongHoldLen = 300;
  localparam int DrainCycles = 16;
  localparam int TimeLimit   = 20_000_000;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       chunk_end;
    logic       known;
    out_t       result;
  } directed_row_t;

  typedef struct {
    in_t  req;
    logic known;
    out_t result;
  } stim_t;

  // result typed in only where it is obvious; other rows go through the predictor
  localparam directed_row_t DirectedRows [NumDirected] = '{
    '{8'h04, 1'b1, 1'b1, '{8'h04, KIND_READY, 1'b1, 11'd1, 1'b0, 1'b0}},
    '{8'h05, 1'b1, 1'b1, '{8'h05, KIND_IDLE, 1'b1, 11'd1, 1'b0, 1'b0}},
    '{8'h15, 1'b0, 1'b1, '{8'h15, KIND_ERROR, 1'b1, 11'd1, 1'b0, 1'b0}},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b0, '0},
    '{8'h10, 1'b0, 1'b1, '{8'h10, KIND_STATUS, 1'b0, 11'd1, 1'b0, 1'b0}},
    '{8'hff, 1'b1, 1'b1, '{8'hff, KIND_STATUS, 1'b1, 11'd2, 1'b0, 1'b0}},
    '{8'h01, 1'b0, 1'b1, '{8'h01, KIND_CHECKSUM, 1'b0, 11'd1, 1'b0, 1'b0}},
    '{8'h03, 1'b1, 1'b1, '{8'h03, KIND_CHECKSUM, 1'b0, 11'd2, 1'b0, 1'b0}},
    '{8'hfe, 1'b1, 1'b1, '{8'hfe, KIND_CHECKSUM, 1'b1, 11'd3, 1'b1, 1'b0}},
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'haa, 1'b0, 1'b0, '0},
    '{8'h55, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'h17, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b1, '{8'h00, KIND_CHECKSUM, 1'b1, 11'd7, 1'b1, 1'b0}},
    '{8'h33, 1'b1, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, '0},
    '{8'h7f, 1'b1, 1'b0, '0},
    '{8'h04, 1'b1, 1'b1, '{8'h04, KIND_DATA, 1'b1, 11'd3, 1'b0, 1'b0}},
    '{8'h03, 1'b0, 1'b0, '0},
    '{8'h04, 1'b1, 1'b0, '0},
    '{8'h00, 1'b1, 1'b0, '0},
    '{8'h04, 1'b1, 1'b0, '0}
  };

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  stim_t       stim_plan[$];
  out_t        pending_frame_bytes[$];
  int unsigned mismatch_cnt;
  int unsigned results_seen;

  // predictor state
  frame_kind_e cur_kind;
  bit          in_frame;
  int unsigned byte_cnt;
  logic [7:0]  xor_acc;
  bit          want_checksum;
  bit          skip_to_chunk_end;

  typed_frame_deframer_xor_check_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  function automatic bit deframe_byte(input in_t req, output out_t res);
    logic [7:0]  b;
    logic [7:0]  chk;
    bit          last;
    bit          ok;
    bit          ovf;
    int unsigned idx;
    b   = req.rx_byte;
    res = '0;
    if (skip_to_chunk_end) begin
      if (req.chunk_end) skip_to_chunk_end = 1'b0;
      return 1'b0;
    end
    if (!in_frame) begin
      case (b)
        ByteEot: cur_kind = KIND_READY;
        ByteEnq: cur_kind = KIND_IDLE;
        ByteNak: cur_kind = KIND_ERROR;
        ByteDle: cur_kind = KIND_STATUS;
        ByteSoh: cur_kind = KIND_CHECKSUM;
        default: cur_kind = KIND_DATA;
      endcase
      byte_cnt      = 0;
      xor_acc       = 8'h00;
      want_checksum = 1'b0;
      in_frame      = 1'b1;
    end
    last = 1'b0;
    ok   = 1'b0;
    ovf  = 1'b0;
    idx  = byte_cnt;
    if (byte_cnt >= MaxFrameLen) ovf = 1'b1;
    else byte_cnt++;
    if (idx == 0) begin
      last = cur_kind inside {KIND_READY, KIND_IDLE, KIND_ERROR};
    end else if (cur_kind == KIND_STATUS) begin
      last = 1'b1;
    end else if (cur_kind == KIND_DATA) begin
      last = (b == ByteEot);
    end else if (cur_kind == KIND_CHECKSUM) begin
      if (want_checksum) begin
        // idx is one past the terminator here
        chk  = (idx < ChkStartIdx) ? ShortCheck : xor_acc;
        ok   = (chk == b);
        last = 1'b1;
      end else begin
        if (idx >= ChkStartIdx) xor_acc ^= b;
        if (b == ByteEtx || b == ByteEtb) want_checksum = 1'b1;
      end
    end
    res.frame_byte      = b;
    res.frame_kind      = cur_kind;
    res.frame_last      = last;
    res.frame_length    = LenW'(byte_cnt);
    res.check_ok        = ok;
    res.length_overflow = ovf;
    if (last) begin
      in_frame      = 1'b0;
      want_checksum = 1'b0;
      if (!req.chunk_end) skip_to_chunk_end = 1'b1;
    end
    return 1'b1;
  endfunction

  // mostly well-formed frames with random content, some noise and cut-off frames
  function automatic void queue_frame(input int sel, input int unsigned n_lo, n_hi);
    logic [7:0]  body[$];
    logic [7:0]  b;
    logic [7:0]  chk;
    int unsigned n;
    bit          framed;
    stim_t       s;
    s.req    = '0;
    s.known  = 1'b0;
    s.result = '0;
    framed   = 1'b1;
    if (sel < 0) sel = $urandom_range(0, 19);
    n = $urandom_range(n_hi, n_lo);
    case (sel)
      0, 1, 2: begin
        case ($urandom_range(0, 2))
          0:       b = ByteEot;
          1:       b = ByteEnq;
          default: b = ByteNak;
        endcase
        body.push_back(b);
      end
      3, 4: begin
        body.push_back(ByteDle);
        body.push_back(8'($urandom));
      end
      5, 6, 7, 8, 9: begin
        do b = 8'($urandom);
        while (b inside {ByteEot, ByteEnq, ByteNak, ByteDle, ByteSoh});
        body.push_back(b);
        repeat (n) begin
          do b = 8'($urandom); while (b == ByteEot);
          body.push_back(b);
        end
        body.push_back(ByteEot);
      end
      10, 11, 12, 13, 14, 15, 16, 17: begin
        body.push_back(ByteSoh);
        repeat (n) begin
          do b = 8'($urandom); while (b == ByteEtx || b == ByteEtb);
          body.push_back(b);
        end
        body.push_back($urandom_range(0, 1) ? ByteEtx : ByteEtb);
        if (body.size() - 1 < ChkStartIdx - 1) begin
          chk = ShortCheck;
        end else begin
          chk = 8'h00;
          for (int k = ChkStartIdx; k < body.size(); k++) chk ^= body[k];
        end
        body.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : chk);
      end
      default: begin
        framed = 1'b0;
        repeat (n % 4 + 1) body.push_back(8'($urandom));
      end
    endcase
    if (framed && $urandom_range(0, 19) == 0) void'(body.pop_back());
    foreach (body[k]) begin
      s.req.rx_byte   = body[k];
      s.req.chunk_end = (k == body.size() - 1) ? 1'($urandom_range(0, 1))
                                               : ($urandom_range(0, 3) == 0);
      stim_plan.push_back(s);
    end
    // frame ended mid-chunk: the rest of the chunk is dropped
    if (framed && !s.req.chunk_end) begin
      repeat ($urandom_range(0, 3)) begin
        s.req.rx_byte   = 8'($urandom);
        s.req.chunk_end = 1'b0;
        stim_plan.push_back(s);
      end
      s.req.rx_byte   = 8'($urandom);
      s.req.chunk_end = 1'b1;
      stim_plan.push_back(s);
    end
  endfunction

  function automatic void build_plan();
    stim_t s;
    bit    long_done;
    long_done = 1'b0;
    for (int i = 0; i < NumDirected; i++) begin
      s.req.rx_byte   = DirectedRows[i].rx_byte;
      s.req.chunk_end = DirectedRows[i].chunk_end;
      s.known         = DirectedRows[i].known;
      s.result        = DirectedRows[i].result;
      stim_plan.push_back(s);
    end
    while (stim_plan.size() < NumDirected + RandomItems) begin
      if (!long_done && stim_plan.size() > LongFrameAt) begin
        // runs past the length limit so the count saturates
        queue_frame(10, MaxFrameLen + 6, MaxFrameLen + 6);
        long_done = 1'b1;
      end else begin
        queue_frame(-1, 0, 14);
      end
    end
  endfunction

  function automatic void check_frame_byte(input out_t act);
    out_t want;
    if (pending_frame_bytes.size() == 0) begin
      $error("frame byte %0h arrived with no result expected", act.frame_byte);
      mismatch_cnt++;
      return;
    end
    want = pending_frame_bytes.pop_front();
    if (act.frame_byte !== want.frame_byte) begin
      $error("frame_byte: expected %0h, got %0h", want.frame_byte, act.frame_byte);
      mismatch_cnt++;
    end
    if (act.frame_kind !== want.frame_kind) begin
      $error("frame_kind: expected %0d, got %0d", want.frame_kind, act.frame_kind);
      mismatch_cnt++;
    end
    if (act.frame_last !== want.frame_last) begin
      $error("frame_last: expected %0b, got %0b", want.frame_last, act.frame_last);
      mismatch_cnt++;
    end
    if (act.frame_length !== want.frame_length) begin
      $error("frame_length: expected %0d, got %0d", want.frame_length, act.frame_length);
      mismatch_cnt++;
    end
    if (act.check_ok !== want.check_ok) begin
      $error("check_ok: expected %0b, got %0b", want.check_ok, act.check_ok);
      mismatch_cnt++;
    end
    if (act.length_overflow !== want.length_overflow) begin
      $error("length_overflow: expected %0b, got %0b",
             want.length_overflow, act.length_overflow);
      mismatch_cnt++;
    end
  endfunction

  function automatic int unsigned rx_stall(input int unsigned n);
    if (n == LongHoldAt) return LongHoldLen;
    if ((n / 120) % 4 == 3) return 0;
    return $urandom_range(0, 15);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #(TimeLimit);
    $display("Verification failed");
    $finish;
  end

  initial begin : sender
    int unsigned gap;
    bit          has_result;
    out_t        predicted;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    mismatch_cnt = 0;
    cur_kind          = KIND_READY;
    in_frame          = 1'b0;
    byte_cnt          = 0;
    xor_acc           = 8'h00;
    want_checksum     = 1'b0;
    skip_to_chunk_end = 1'b0;
    build_plan();
    wait (rst_ni);
    @(posedge clk_i);
    for (int i = 0; i < stim_plan.size(); i++) begin
      if (i == PauseAt) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (pending_frame_bytes.size() != 0);
      end
      gap = ((i / 150) % 3 == 2) ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_data_i  <= stim_plan[i].req;
      do @(posedge clk_i); while (!in_ready_o);
      has_result = deframe_byte(stim_plan[i].req, predicted);
      if (stim_plan[i].known) pending_frame_bytes.push_back(stim_plan[i].result);
      else if (has_result) pending_frame_bytes.push_back(predicted);
    end
    in_valid_i <= 1'b0;
    while (pending_frame_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned wait_left;
    out_ready_i <= 1'b0;
    results_seen = 0;
    wait (rst_ni);
    wait_left = rx_stall(results_seen);
    forever begin
      @(posedge clk_i);
      if (out_ready_i && out_valid_o) begin
        check_frame_byte(out_data_o);
        results_seen++;
        wait_left = rx_stall(results_seen);
      end else if (wait_left > 0) begin
        wait_left--;
      end
      out_ready_i <= (wait_left == 0);
    end
  end

endmodule
